FILE: hw/rtl/isp_pkg.sv
// Shared types, codes and character helpers for the infix-to-postfix converter.
// No dependencies; imported by every module of the block but isp_ram.
package isp_pkg;

  // Default operator stack depth (entries)
  localparam int STACK_DEPTH_DEF = 32;
  // Entries in the queue between the front and the back
  localparam int QDEPTH = 2;

  // Characters with a meaning
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNMATCHED = 2'd2;

  // Operator ranks
  localparam logic [1:0] RANK_ADD = 2'd0;
  localparam logic [1:0] RANK_MUL = 2'd1;
  localparam logic [1:0] RANK_POW = 2'd2;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expression;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] status;
    logic       run_last;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_OPERAND = 2'd0,
    KIND_OPER    = 2'd1,
    KIND_OPEN    = 2'd2,
    KIND_CLOSE   = 2'd3
  } kind_t;

  // Classified item as it sits in the front queue
  typedef struct packed {
    in_item_t   item;
    kind_t      kind;
    logic [1:0] rank;
  } cls_item_t;

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_MUL) ||
           (c == CH_DIV) || (c == CH_POW);
  endfunction

  function automatic logic [1:0] op_rank(input logic [7:0] c);
    logic [1:0] r;
    r = RANK_ADD;
    if ((c == CH_MUL) || (c == CH_DIV)) r = RANK_MUL;
    if (c == CH_POW) r = RANK_POW;
    return r;
  endfunction

endpackage

FILE: hw/rtl/isp_ram.sv
// Generic single-write, single-read RAM with registered read (old data on collision).
// No dependencies.
module isp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/isp_front.sv
// Front end: accepts input transfers, classifies each symbol, queues it for the back.
// Depends on isp_pkg.
module isp_front
  import isp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  output logic      q_valid,
  output cls_item_t q_item,
  input  logic      q_take
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cls_item_t         entry_r [QDEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  cls_item_t         cls;
  logic              wr_en;
  logic              rd_en;

  // Classify the incoming symbol
  always_comb begin
    cls.item = in_data;
    cls.rank = op_rank(in_data.symbol);
    if (is_op(in_data.symbol)) begin
      cls.kind = KIND_OPER;
    end else if (in_data.symbol == CH_OPEN) begin
      cls.kind = KIND_OPEN;
    end else if (in_data.symbol == CH_CLOSE) begin
      cls.kind = KIND_CLOSE;
    end else begin
      cls.kind = KIND_OPERAND;
    end
  end

  assign full    = (cnt_r == CW'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = entry_r[rd_ptr_r];
  assign wr_en   = push && !full;
  assign rd_en   = q_take && q_valid;

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(wr_en) - CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r] <= cls;
    end
  end

endmodule

FILE: hw/rtl/isp_back.sv
// Back end: shunting-yard sequencer with operator stack, result staging and output register.
// Depends on isp_pkg and isp_ram.
module isp_back
  import isp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cls_item_t q_item,
  output logic      q_take,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_OPER    = 7'b0000010,
    S_OPEN    = 7'b0000100,
    S_CLOSE   = 7'b0001000,
    S_OPERAND = 7'b0010000,
    S_DRAIN   = 7'b0100000,
    S_FIN     = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  cls_item_t  cur_r, cur_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0] top_r, top_nxt;
  logic       sec_byp_r, sec_byp_nxt;
  logic [7:0] sec_val_r, sec_val_nxt;
  logic       hold_v_r, hold_v_nxt;
  logic [7:0] hold_ch_r, hold_ch_nxt;
  logic [1:0] hold_st_r, hold_st_nxt;
  logic       out_v_r, out_v_nxt;
  out_item_t  out_r, out_nxt;

  logic [7:0] sec;
  logic [7:0] ram_rdata;
  logic [AW-1:0] ram_raddr;
  logic       out_free, emit_ok;
  logic       do_emit, do_push, do_pop, do_fin, do_load;
  logic [7:0] emit_ch;
  logic [1:0] emit_st;
  logic [7:0] push_ch;
  logic       stk_empty, stk_full;
  state_t     after_sym;

  // Entry under the top: from the RAM, or the old top right after a push
  assign sec       = sec_byp_r ? sec_val_r : ram_rdata;
  assign out_free  = !out_v_r || pop;
  assign emit_ok   = !hold_v_r || out_free;
  assign stk_empty = (count_r == '0);
  assign stk_full  = (count_r == CW'(STACK_DEPTH));
  assign after_sym = cur_r.item.end_of_expression ? S_DRAIN : S_FIN;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    do_emit   = 1'b0;
    emit_ch   = top_r;
    emit_st   = ST_OK;
    do_push   = 1'b0;
    push_ch   = cur_r.item.symbol;
    do_pop    = 1'b0;
    do_fin    = 1'b0;
    do_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        do_load = q_valid;
      end
      S_OPER: begin
        if (!stk_empty && is_op(top_r) && (op_rank(top_r) >= cur_r.rank)) begin
          if (emit_ok) begin
            do_emit = 1'b1;
            do_pop  = 1'b1;
          end
        end else if (!stk_full) begin
          do_push   = 1'b1;
          state_nxt = after_sym;
        end else if (emit_ok) begin
          do_emit   = 1'b1;
          emit_ch   = cur_r.item.symbol;
          emit_st   = ST_OVERFLOW;
          state_nxt = after_sym;
        end
      end
      S_OPEN: begin
        if (!stk_full) begin
          do_push   = 1'b1;
          state_nxt = after_sym;
        end else if (emit_ok) begin
          do_emit   = 1'b1;
          emit_ch   = cur_r.item.symbol;
          emit_st   = ST_OVERFLOW;
          state_nxt = after_sym;
        end
      end
      S_CLOSE: begin
        if (stk_empty) begin
          if (emit_ok) begin
            do_emit   = 1'b1;
            emit_ch   = CH_CLOSE;
            emit_st   = ST_UNMATCHED;
            state_nxt = after_sym;
          end
        end else if (top_r == CH_OPEN) begin
          do_pop    = 1'b1;
          state_nxt = after_sym;
        end else if (emit_ok) begin
          do_emit = 1'b1;
          do_pop  = 1'b1;
        end
      end
      S_OPERAND: begin
        if (emit_ok) begin
          do_emit   = 1'b1;
          emit_ch   = cur_r.item.symbol;
          state_nxt = after_sym;
        end
      end
      S_DRAIN: begin
        if (stk_empty) begin
          state_nxt = S_FIN;
        end else if (top_r == CH_OPEN) begin
          do_pop = 1'b1;
        end else if (emit_ok) begin
          do_emit = 1'b1;
          do_pop  = 1'b1;
        end
      end
      S_FIN: begin
        // Flag the staged result, if any, as last, then move on to the next item
        if (!hold_v_r) begin
          do_load   = q_valid;
          state_nxt = S_IDLE;
        end else if (out_free) begin
          do_fin    = 1'b1;
          do_load   = q_valid;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Load the next queued item and dispatch on its kind
    cur_nxt = cur_r;
    if (do_load) begin
      cur_nxt = q_item;
      case (q_item.kind)
        KIND_OPER:  state_nxt = S_OPER;
        KIND_OPEN:  state_nxt = S_OPEN;
        KIND_CLOSE: state_nxt = S_CLOSE;
        default:    state_nxt = S_OPERAND;
      endcase
    end
  end

  assign q_take = do_load;

  // Stack: top in a register, deeper entries in the RAM
  always_comb begin
    count_nxt   = count_r;
    top_nxt     = top_r;
    sec_byp_nxt = 1'b0;
    sec_val_nxt = sec_val_r;
    if (do_pop) begin
      count_nxt = count_r - 1'b1;
      top_nxt   = sec;
    end else if (do_push) begin
      count_nxt   = count_r + 1'b1;
      top_nxt     = push_ch;
      sec_byp_nxt = 1'b1;
      sec_val_nxt = top_r;
    end
  end

  logic [CW-1:0] raddr_full;
  logic [CW-1:0] waddr_full;
  assign raddr_full = count_nxt - CW'(2);
  assign waddr_full = count_r - 1'b1;
  assign ram_raddr  = raddr_full[AW-1:0];

  isp_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (do_push && !stk_empty),
    .waddr (waddr_full[AW-1:0]),
    .wdata (top_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result staging: one result held back until the next one shows its run_last bit
  always_comb begin
    hold_v_nxt  = hold_v_r;
    hold_ch_nxt = hold_ch_r;
    hold_st_nxt = hold_st_r;
    out_v_nxt   = out_v_r && !pop;
    out_nxt     = out_r;
    if (do_emit) begin
      if (hold_v_r) begin
        out_v_nxt        = 1'b1;
        out_nxt.out_char = hold_ch_r;
        out_nxt.status   = hold_st_r;
        out_nxt.run_last = 1'b0;
      end
      hold_v_nxt  = 1'b1;
      hold_ch_nxt = emit_ch;
      hold_st_nxt = emit_st;
    end else if (do_fin) begin
      out_v_nxt        = 1'b1;
      out_nxt.out_char = hold_ch_r;
      out_nxt.status   = hold_st_r;
      out_nxt.run_last = 1'b1;
      hold_v_nxt       = 1'b0;
    end
  end

  assign empty    = !out_v_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      sec_byp_r <= 1'b0;
      hold_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      sec_byp_r <= sec_byp_nxt;
      hold_v_r  <= hold_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    top_r     <= top_nxt;
    sec_val_r <= sec_val_nxt;
    hold_ch_r <= hold_ch_nxt;
    hold_st_r <= hold_st_nxt;
    out_r     <= out_nxt;
  end

endmodule

FILE: hw/rtl/infix_to_postfix_converter.sv
// Top level of the shunting-yard infix-to-postfix converter.
// Depends on isp_pkg, isp_front, isp_back (and isp_ram below it).
//
//  channel  dir  handshake            payload
//  input    in   push / full          in_data  (symbol, end_of_expression)
//  result   out  empty / pop          out_data (out_char, status, run_last)
//
// The back end handles each item in a state for its kind; an operator or ')' first
// pops stacked operators, and a drain pops every stacked entry. The stack RAM has one
// write and one registered read port, so the stack moves one entry per cycle unless
// the output stalls; the output register takes one result a cycle while it is popped.
// Reset empties the stack and queues at once; stack RAM contents are not cleared.
// A two-entry front queue keeps taking transfers while the back end works or stalls, until full.
module infix_to_postfix_converter
  import isp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  logic      q_valid;
  logic      q_take;
  cls_item_t q_item;

  isp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take)
  );

  isp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_take   (q_take),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  // The back end only takes from a non-empty queue
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid)
    else $error("back end took from an empty queue");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.status == ST_OK || out_data.status == ST_OVERFLOW ||
                out_data.status == ST_UNMATCHED))
    else $error("undefined status code on result");

  // The queue fills only through an input transfer
  a_full_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full) |-> $past(push))
    else $error("queue became full without an input transfer");

endmodule

FILE: dv/tb_infix_to_postfix_converter.sv
`timescale 1ns / 100ps
// Testbench for infix_to_postfix_converter: directed and random infix streams,
// checked character by character against a shunting-yard scoreboard.
// Depends on isp_pkg and the converter RTL only.
module tb_infix_to_postfix_converter;
  import isp_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 90;

  // Shunting-yard scoreboard: predicts postfix output and checks each transfer
  class postfix_checker;
    logic [7:0] op_stack [STACK_DEPTH_DEF];
    int unsigned op_depth;
    out_item_t   pending_chars[$];
    out_item_t   run_chars[$];
    int errors;
    int n_checked;
    int n_overflow;
    int n_unmatched;
    int n_drain;

    function new();
      op_depth    = 0;
      errors      = 0;
      n_checked   = 0;
      n_overflow  = 0;
      n_unmatched = 0;
      n_drain     = 0;
    endfunction

    // -1 marks a non-operator
    function int rank_for(logic [7:0] c);
      case (c)
        CH_PLUS, CH_MINUS: return int'(RANK_ADD);
        CH_MUL, CH_DIV:    return int'(RANK_MUL);
        CH_POW:            return int'(RANK_POW);
        default:           return -1;
      endcase
    endfunction

    function void emit_char(logic [7:0] ch, logic [1:0] st);
      out_item_t r;
      r.out_char = ch;
      r.status   = st;
      r.run_last = 1'b0;
      run_chars.push_back(r);
    endfunction

    // Full stack drops the push and reports it
    function void stack_push(logic [7:0] ch);
      if (op_depth < STACK_DEPTH_DEF) begin
        op_stack[op_depth] = ch;
        op_depth++;
      end else begin
        emit_char(ch, ST_OVERFLOW);
        n_overflow++;
      end
    endfunction

    // Note one accepted symbol and queue the characters it produces
    function void convert_symbol(in_item_t it);
      logic [7:0] sym;
      logic [7:0] top;
      int rk;
      bit matched;
      sym = it.symbol;
      rk  = rank_for(sym);
      run_chars.delete();
      if (rk >= 0) begin
        // pop equal or higher rank; '(' ranks -1 and stops the loop
        while (op_depth > 0 && rank_for(op_stack[op_depth-1]) >= rk) begin
          emit_char(op_stack[op_depth-1], ST_OK);
          op_depth--;
        end
        stack_push(sym);
      end else if (sym == CH_OPEN) begin
        stack_push(sym);
      end else if (sym == CH_CLOSE) begin
        matched = 1'b0;
        while (op_depth > 0 && !matched) begin
          top = op_stack[op_depth-1];
          op_depth--;
          if (top == CH_OPEN) matched = 1'b1;
          else emit_char(top, ST_OK);
        end
        if (!matched) begin
          emit_char(CH_CLOSE, ST_UNMATCHED);
          n_unmatched++;
        end
      end else begin
        emit_char(sym, ST_OK);
      end
      // end of expression: drain, dropping leftover '('
      if (it.end_of_expression) begin
        if (op_depth > 0) n_drain++;
        while (op_depth > 0) begin
          top = op_stack[op_depth-1];
          op_depth--;
          if (top != CH_OPEN) emit_char(top, ST_OK);
        end
      end
      if (run_chars.size() > 0) run_chars[run_chars.size()-1].run_last = 1'b1;
      foreach (run_chars[i]) pending_chars.push_back(run_chars[i]);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("%0t ERROR %s", $time, what);
    endtask

    task check_char(out_item_t got);
      out_item_t want;
      if (pending_chars.size() == 0) begin
        report($sformatf("result with nothing pending: char=%02h status=%0d last=%0b",
                         got.out_char, got.status, got.run_last));
        return;
      end
      want = pending_chars.pop_front();
      n_checked++;
      if (got.out_char !== want.out_char)
        report($sformatf("out_char %02h, predicted %02h", got.out_char, want.out_char));
      if (got.status !== want.status)
        report($sformatf("status %0d, predicted %0d (char %02h)",
                         got.status, want.status, want.out_char));
      if (got.run_last !== want.run_last)
        report($sformatf("run_last %0b, predicted %0b (char %02h)",
                         got.run_last, want.run_last, want.out_char));
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_data;
  logic      empty;
  logic      pop;
  out_item_t out_data;

  postfix_checker chk;
  in_item_t stim_q[$];
  int  n_sent;
  int  n_full_waits;
  int  cycle_cnt;
  int  hold_left;
  int  stall_left;
  bit  calm;
  bit  hold_req;

  infix_to_postfix_converter i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("infix_to_postfix_converter: mismatch");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, none in calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_MUL;
      3:       return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  // Letters mostly, now and then any byte that is not an operator or parenthesis
  function automatic logic [7:0] pick_operand();
    logic [7:0] c;
    if ($urandom_range(0, 4) != 0) return 8'h61 + 8'($urandom_range(0, 25));
    do c = 8'($urandom_range(0, 255));
    while (chk.rank_for(c) >= 0 || c == CH_OPEN || c == CH_CLOSE);
    return c;
  endfunction

  function automatic void add_sym(logic [7:0] s, bit e);
    in_item_t it;
    it.symbol            = s;
    it.end_of_expression = e;
    stim_q.push_back(it);
  endfunction

  // Well-formed expression with random content, optionally broken at the end
  function automatic void gen_expression(bit broken);
    int n_opnd;
    int open_cnt;
    int i;
    int how;
    n_opnd   = ($urandom_range(0, 29) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
    open_cnt = 0;
    for (i = 0; i < n_opnd; i++) begin
      while (open_cnt < 8 && $urandom_range(0, 3) == 0) begin
        add_sym(CH_OPEN, 1'b0);
        open_cnt++;
      end
      add_sym(pick_operand(), 1'b0);
      while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
        add_sym(CH_CLOSE, 1'b0);
        open_cnt--;
      end
      if (i < n_opnd - 1) add_sym(pick_operator(), 1'b0);
    end
    how = broken ? $urandom_range(0, 2) : 3;
    if (how != 1) begin
      while (open_cnt > 0) begin
        add_sym(CH_CLOSE, 1'b0);
        open_cnt--;
      end
    end
    if (how == 0) add_sym(CH_CLOSE, 1'b0);
    if (how == 2) add_sym(pick_operator(), 1'b0);
    // a broken one sometimes leaves its stack behind for the next expression
    if (!broken || $urandom_range(0, 3) != 0)
      stim_q[stim_q.size()-1].end_of_expression = 1'b1;
  endfunction

  // Offer one symbol and wait for its transfer
  task send_item(in_item_t it);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push    <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) begin
      n_full_waits++;
      @(posedge clk);
    end
    chk.convert_symbol(it);
    n_sent++;
  endtask

  task send_queued();
    while (stim_q.size() > 0) send_item(stim_q.pop_front());
  endtask

  // Result side: random pops, one long hold-off on request
  initial begin
    pop        = 1'b0;
    hold_left  = 0;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        stall_left = pick_gap();
      end
      @(posedge clk);
      if (pop && !empty) chk.check_char(out_data);
    end
  end

  // Stimulus and end of run
  initial begin
    int i;
    int target;
    int pick;
    chk          = new();
    rst_n        = 1'b0;
    push         = 1'b0;
    in_data      = '0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    n_sent       = 0;
    n_full_waits = 0;
    cycle_cnt    = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: each operator and rank, both associativity cases, parentheses
    add_sym("a", 1'b0);
    add_sym(CH_PLUS, 1'b0);
    add_sym("b", 1'b0);
    add_sym(CH_MUL, 1'b0);
    add_sym("c", 1'b0);
    add_sym(CH_POW, 1'b0);
    add_sym("d", 1'b0);
    add_sym(CH_POW, 1'b0);
    add_sym("e", 1'b0);
    add_sym(CH_MINUS, 1'b0);
    add_sym(CH_OPEN, 1'b0);
    add_sym("f", 1'b0);
    add_sym(CH_DIV, 1'b0);
    add_sym("g", 1'b0);
    add_sym(CH_CLOSE, 1'b0);
    add_sym(8'h00, 1'b0);
    add_sym(8'hFF, 1'b1);
    // close on an empty stack, then open left behind at the end
    add_sym(CH_CLOSE, 1'b1);
    add_sym(CH_OPEN, 1'b0);
    add_sym("x", 1'b1);
    // unmatched close with operators stacked
    add_sym("a", 1'b0);
    add_sym(CH_PLUS, 1'b0);
    add_sym("b", 1'b0);
    add_sym(CH_CLOSE, 1'b0);
    add_sym(CH_MINUS, 1'b1);
    send_queued();

    // fill the stack, then push an operator and a parenthesis onto it
    for (i = 0; i < STACK_DEPTH_DEF; i++) add_sym(CH_OPEN, 1'b0);
    add_sym(CH_PLUS, 1'b0);
    add_sym(CH_OPEN, 1'b0);
    add_sym("q", 1'b1);
    send_queued();

    // random part; the receiver holds off at the start so the input backs up
    hold_req = 1'b1;
    target   = n_sent + RANDOM_ITEMS;
    while (n_sent < target) begin
      calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        gen_expression(1'b0);
      end else if (pick < 85) begin
        gen_expression(1'b1);
      end else begin
        repeat ($urandom_range(1, 4))
          add_sym(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      send_queued();
    end
    @(negedge clk);
    push <= 1'b0;
    calm = 1'b0;

    while (chk.pending_chars.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("sent %0d symbols, checked %0d characters, %0d overflows, %0d unmatched closes",
             n_sent, chk.n_checked, chk.n_overflow, chk.n_unmatched);
    $display("%0d drains with operators left, input held by full for %0d cycles",
             chk.n_drain, n_full_waits);
    if (chk.errors == 0 && chk.pending_chars.size() == 0) begin
      $display("infix_to_postfix_converter: match");
    end else begin
      $display("%0d errors, %0d characters never arrived", chk.errors,
               chk.pending_chars.size());
      $display("infix_to_postfix_converter: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/isp_pkg.sv
hw/rtl/isp_ram.sv
hw/rtl/isp_front.sv
hw/rtl/isp_back.sv
hw/rtl/infix_to_postfix_converter.sv
dv/tb_infix_to_postfix_converter.sv
